/* src/msec_pkg.sv */
// shared types, constants and result formatting for the encoded min-stack
`timescale 1ns / 1ps

package msec_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int STACK_DEPTH = 64;
    localparam int ENTRY_WIDTH = DATA_WIDTH + 2;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = 7;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOAD
    } fsm_t;

    typedef struct packed {
        logic                          req_type;
        logic signed [DATA_WIDTH-1:0]  push_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  top_value;
        logic signed [DATA_WIDTH-1:0]  least_value;
        logic                          is_empty;
        logic [COUNT_W-1:0]            entry_count;
        logic [1:0]                    status;
    } rsp_t;

    // next state of one operation, from the update logic to the top level
    typedef struct packed {
        logic [1:0]                    status;
        logic [COUNT_W-1:0]            fill_next;
        logic signed [DATA_WIDTH-1:0]  min_next;
        logic [ENTRY_WIDTH-1:0]        top_word_next;
        logic                          wr_en;
        logic [ADDR_W-1:0]             wr_addr;
        logic [ENTRY_WIDTH-1:0]        wr_data;
        logic                          rd_en;
        logic [ADDR_W-1:0]             rd_addr;
    } upd_t;

    function automatic rsp_t make_result(
        input logic [COUNT_W-1:0]           fill,
        input logic signed [DATA_WIDTH-1:0] min_val,
        input logic [ENTRY_WIDTH-1:0]       top_word,
        input logic [1:0]                   status
    );
        rsp_t                          r;
        logic signed [ENTRY_WIDTH-1:0] min_ext;
        min_ext       = {{(ENTRY_WIDTH-DATA_WIDTH){min_val[DATA_WIDTH-1]}}, min_val};
        r.entry_count = fill;
        r.status      = status;
        r.is_empty    = (fill == '0);
        if (fill == '0)
        begin
            r.top_value   = '1;
            r.least_value = '1;
        end
        else
        begin
            r.least_value = min_val;
            if ($signed(top_word) > min_ext)
                r.top_value = top_word[DATA_WIDTH-1:0];
            else
                r.top_value = min_val;
        end
        return r;
    endfunction

endpackage

/* src/msec_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module msec_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

/* src/msec_update.sv */
// push/pop arithmetic: encoded store word, minimum restore, memory access
`timescale 1ns / 1ps

module msec_update (
    input  msec_pkg::req_t                          req,
    input  logic [msec_pkg::COUNT_W-1:0]            capacity,
    input  logic [msec_pkg::COUNT_W-1:0]            fill,
    input  logic signed [msec_pkg::DATA_WIDTH-1:0]  min_val,
    input  logic [msec_pkg::ENTRY_WIDTH-1:0]        top_word,
    output msec_pkg::upd_t                          upd
);

    logic [msec_pkg::COUNT_W-1:0]            cap_eff;
    logic signed [msec_pkg::ENTRY_WIDTH-1:0] val_ext;
    logic signed [msec_pkg::ENTRY_WIDTH-1:0] min_ext;
    logic signed [msec_pkg::ENTRY_WIDTH-1:0] enc_word;
    logic signed [msec_pkg::ENTRY_WIDTH-1:0] restore;
    logic [msec_pkg::COUNT_W-1:0]            fill_dec;
    logic [msec_pkg::COUNT_W-1:0]            fill_dec2;

    assign cap_eff  = (capacity > msec_pkg::COUNT_W'(msec_pkg::STACK_DEPTH))
                    ? msec_pkg::COUNT_W'(msec_pkg::STACK_DEPTH) : capacity;
    assign val_ext  = {{(msec_pkg::ENTRY_WIDTH-msec_pkg::DATA_WIDTH){req.push_value[msec_pkg::DATA_WIDTH-1]}},
                       req.push_value};
    assign min_ext  = {{(msec_pkg::ENTRY_WIDTH-msec_pkg::DATA_WIDTH){min_val[msec_pkg::DATA_WIDTH-1]}},
                       min_val};
    assign enc_word = (val_ext <<< 1) - min_ext;
    assign restore  = (min_ext <<< 1) - $signed(top_word);
    assign fill_dec  = fill - msec_pkg::COUNT_W'(1);
    assign fill_dec2 = fill - msec_pkg::COUNT_W'(2);

    always_comb
    begin
        upd.status        = msec_pkg::ST_OK;
        upd.fill_next     = fill;
        upd.min_next      = min_val;
        upd.top_word_next = top_word;
        upd.wr_en         = 1'b0;
        upd.wr_addr       = fill[msec_pkg::ADDR_W-1:0];
        upd.wr_data       = val_ext;
        upd.rd_en         = 1'b0;
        upd.rd_addr       = fill_dec2[msec_pkg::ADDR_W-1:0];
        if (req.req_type == msec_pkg::REQ_PUSH)
        begin
            if (fill >= cap_eff)
                upd.status = msec_pkg::ST_OVERFLOW;
            else
            begin
                upd.wr_en     = 1'b1;
                upd.fill_next = fill + msec_pkg::COUNT_W'(1);
                if (fill == '0 || val_ext > min_ext)
                    upd.wr_data = val_ext;
                else
                    upd.wr_data = enc_word;
                if (fill == '0 || !(val_ext > min_ext))
                    upd.min_next = req.push_value;
                upd.top_word_next = upd.wr_data;
            end
        end
        else
        begin
            if (fill == '0)
                upd.status = msec_pkg::ST_UNDERFLOW;
            else
            begin
                upd.fill_next = fill_dec;
                // stored word at or below the minimum marks an encoded entry
                if (!($signed(top_word) > min_ext))
                    upd.min_next = restore[msec_pkg::DATA_WIDTH-1:0];
                // new top lives one below in the memory
                upd.rd_en = (fill_dec != '0);
            end
        end
    end

endmodule

/* src/min_stack_encoded_unit.sv */
// top level of the encoded min-stack: control, state registers, result register
`timescale 1ns / 1ps

// Stack of signed 32-bit values that reports its minimum without a second
// store: a push at or below the minimum stores 2*value-minimum (34 bits) and
// a pop of such an entry restores the previous minimum. Every request beat
// yields one response beat with the decoded top, the minimum (both all ones
// when empty), the empty flag, the element count and a status code (ok,
// overflow on a full push, underflow on an empty pop; on either error nothing
// changes). The entries live in a 64 x 34 ram with registered read data;
// a copy of the top entry sits in a register next to the fill count and the
// minimum. A push, an error, or a pop that empties the stack is answered
// from the idle state; a pop that leaves elements behind waits in the load
// state on the ram read of the new top entry. A response waiting in the output
// register does not block the next request beat unless it is stalled.
// The capacity register (1..64, values above 64 act as 64) is written
// through the cfg port, always ready; write it only while the block is idle.
module min_stack_encoded_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  msec_pkg::req_t                req_beat,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output msec_pkg::rsp_t                rsp_beat,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [msec_pkg::COUNT_W-1:0]  cfg_data
);

    // control state
    msec_pkg::fsm_t                          state_reg, state_next;
    logic [msec_pkg::COUNT_W-1:0]            capacity_reg;
    logic [msec_pkg::COUNT_W-1:0]            fill_reg, fill_next;
    logic signed [msec_pkg::DATA_WIDTH-1:0]  min_reg, min_next;
    logic                                    rsp_valid_reg, rsp_valid_next;

    // payload
    logic [msec_pkg::ENTRY_WIDTH-1:0]        top_word_reg, top_word_next;
    msec_pkg::rsp_t                          rsp_beat_reg, rsp_beat_next;

    logic                                    req_fire;
    msec_pkg::upd_t                          upd;
    logic [msec_pkg::ENTRY_WIDTH-1:0]        rd_data;

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

    // no new beat while a read is pending or the response is held up
    assign req_stall = (state_reg != msec_pkg::S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign req_fire  = req_valid && !req_stall;

    msec_update u_update (
        .req      (req_beat),
        .capacity (capacity_reg),
        .fill     (fill_reg),
        .min_val  (min_reg),
        .top_word (top_word_reg),
        .upd      (upd)
    );

    msec_ram #(
        .WIDTH (msec_pkg::ENTRY_WIDTH),
        .DEPTH (msec_pkg::STACK_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (req_fire && upd.wr_en),
        .wr_addr (upd.wr_addr),
        .wr_data (upd.wr_data),
        .rd_en   (req_fire && upd.rd_en),
        .rd_addr (upd.rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        min_next       = min_reg;
        top_word_next  = top_word_reg;
        rsp_beat_next  = rsp_beat_reg;
        rsp_valid_next = rsp_valid_reg;

        // response taken by the consumer
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            msec_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    fill_next     = upd.fill_next;
                    min_next      = upd.min_next;
                    top_word_next = upd.top_word_next;
                    if (upd.rd_en)
                        state_next = msec_pkg::S_LOAD;
                    else
                    begin
                        rsp_beat_next  = msec_pkg::make_result(upd.fill_next, upd.min_next,
                                                               upd.top_word_next, upd.status);
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            msec_pkg::S_LOAD:
            begin
                // new top entry arrives from the ram; pop always succeeded here
                top_word_next  = rd_data;
                rsp_beat_next  = msec_pkg::make_result(fill_reg, min_reg, rd_data,
                                                       msec_pkg::ST_OK);
                rsp_valid_next = 1'b1;
                state_next     = msec_pkg::S_IDLE;
            end
            default:
            begin
                state_next = msec_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msec_pkg::S_IDLE;
            capacity_reg  <= msec_pkg::COUNT_W'(msec_pkg::STACK_DEPTH);
            fill_reg      <= '0;
            min_reg       <= {1'b0, {(msec_pkg::DATA_WIDTH-1){1'b1}}};
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            min_reg       <= min_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        top_word_reg <= top_word_next;
        rsp_beat_reg <= rsp_beat_next;
    end

endmodule
